/* design/tscc_pkg.sv */
package tscc_pkg;

  // Fixed field widths
  localparam int SCORE_W    = 32;
  localparam int SEXT_W     = 34;
  localparam int DELTA_W    = 31;
  localparam int NCUT_W     = 7;
  localparam int OUT_CNT_W  = 32;
  localparam int CUT_IDX_W  = 6;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // 1.0 in Q16.16, extended to the working width
  localparam logic [SEXT_W-1:0] ONE_Q16 = 34'h0_0001_0000;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_PAIR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CUTS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER    = 3'd4;

  // Register reset values
  localparam logic [SCORE_W-1:0] MIN_VALUE_RST = 32'd0;
  localparam logic [DELTA_W-1:0] DELTA_RST     = 31'd6554;
  localparam logic [NCUT_W-1:0]  NUM_CUTS_RST  = 7'd11;

  // Operation handed from front to back
  typedef enum logic [1:0] {
    OP_PAIR,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              pos;
    logic              scored;
    logic [SEXT_W-1:0] score;   // two's complement, possibly inverted
  } qent_t;

endpackage

/* design/tscc_if.sv */
// Input request channel
interface tscc_in_if
  import tscc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [SCORE_W-1:0] score;
  logic                      score_valid;
  logic                      answer_valid;
  logic                      is_positive;
  logic                      first_in_set;
  logic                      second_in_set;

  modport source (
    output valid, kind, score, score_valid, answer_valid, is_positive,
           first_in_set, second_in_set,
    input  ready
  );
  modport sink (
    input  valid, kind, score, score_valid, answer_valid, is_positive,
           first_in_set, second_in_set,
    output ready
  );
endinterface

// Result row channel
interface tscc_out_if
  import tscc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CUT_IDX_W-1:0] cut_index;
  logic [OUT_CNT_W-1:0] true_pos;
  logic [OUT_CNT_W-1:0] false_pos;
  logic [OUT_CNT_W-1:0] true_neg;
  logic [OUT_CNT_W-1:0] false_neg;
  logic [OUT_CNT_W-1:0] total_pos;
  logic [OUT_CNT_W-1:0] total_neg;
  logic                 last;

  modport source (
    output valid, cut_index, true_pos, false_pos, true_neg, false_neg,
           total_pos, total_neg, last,
    input  ready
  );
  modport sink (
    input  valid, cut_index, true_pos, false_pos, true_neg, false_neg,
           total_pos, total_neg, last,
    output ready
  );
endinterface

// Register write channel
interface tscc_cfg_if
  import tscc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/tscc_front.sv */
module tscc_front
  import tscc_pkg::*;
(
  tscc_in_if.sink in_ch,
  input  logic    invert_mode,
  input  logic    filter_enable,
  input  logic    q_ready,
  output logic    q_push,
  output qent_t   q_data
);

  logic [SEXT_W-1:0] score_ext;
  logic              admit;
  logic              keep;

  // Sign extend and optionally take one minus score
  assign score_ext = {{(SEXT_W-SCORE_W){in_ch.score[SCORE_W-1]}}, in_ch.score};

  // Admission: needs an answer; filter wants both genes for positives,
  // either gene for negatives
  assign admit = in_ch.answer_valid &&
                 (!filter_enable ||
                  (in_ch.is_positive ? (in_ch.first_in_set && in_ch.second_in_set)
                                     : (in_ch.first_in_set || in_ch.second_in_set)));

  // Classify the request
  always_comb begin
    keep          = 1'b0;
    q_data.op     = OP_PAIR;
    q_data.pos    = in_ch.is_positive;
    q_data.scored = in_ch.score_valid;
    q_data.score  = invert_mode ? (ONE_Q16 - score_ext) : score_ext;
    unique case (in_ch.kind)
      KIND_PAIR: begin
        keep = admit;
      end
      KIND_READ: begin
        keep      = 1'b1;
        q_data.op = OP_READ;
      end
      KIND_CLEAR: begin
        keep      = 1'b1;
        q_data.op = OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Dropped requests are still taken, they just never reach the queue
  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready && keep;

endmodule

/* design/tscc_queue.sv */
module tscc_queue
  import tscc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  push_ready,
  input  logic  pop,
  output logic  head_valid,
  output qent_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  qent_t            ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign push_ready = (count_r != CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = ent_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CNT_FULL)
    else $error("queue written while full");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue read while empty");
`endif

endmodule

/* design/tscc_div.sv */
module tscc_div
  import tscc_pkg::*;
#(
  parameter int CUT_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SEXT_W-1:0] x,      // diff - 1, two's complement
  input  logic [DELTA_W-1:0] d,
  input  logic [CUT_W-1:0]  n,
  output logic              done,
  output logic [CUT_W-1:0]  idx
);

  // Quotient bits: one above the clamp range catches overflow
  localparam int Q_W    = CUT_W + 1;
  localparam int DIV_W  = SEXT_W + CUT_W;
  localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic              busy_r;
  logic              done_r;
  logic [CUT_W-1:0]  idx_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsh_r;
  logic [Q_W-1:0]    q_r;
  logic [STEP_W-1:0] step_r;

  logic              ge;
  logic [DIV_W-1:0]  rem_nxt;
  logic [Q_W-1:0]    q_nxt;

  // One restoring step
  assign ge      = (rem_r >= dsh_r);
  assign rem_nxt = ge ? (rem_r - dsh_r) : rem_r;
  assign q_nxt   = {q_r[Q_W-2:0], ge};

  assign done = done_r;
  assign idx  = idx_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !x[SEXT_W-1];
        done_r <= x[SEXT_W-1];
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: ceil(diff/d) = floor((diff-1)/d) + 1, clamped to n
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= DIV_W'(x[SEXT_W-2:0]);
      dsh_r  <= DIV_W'(d) << CUT_W;
      q_r    <= '0;
      step_r <= STEP_W'(CUT_W);
      idx_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      dsh_r  <= dsh_r >> 1;
      q_r    <= q_nxt;
      step_r <= step_r - STEP_W'(1);
      if (step_r == '0) begin
        idx_r <= (q_nxt >= Q_W'(n)) ? n : CUT_W'(q_nxt + Q_W'(1));
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r)
    else $error("divider reports done while still iterating");
`endif

endmodule

/* design/tscc_back.sv */
module tscc_back
  import tscc_pkg::*;
#(
  parameter int MAX_CUTS    = 64,
  parameter int COUNT_WIDTH = 32,
  parameter int CUT_W       = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  qent_t              head,
  output logic               pop,
  input  logic [SCORE_W-1:0] min_value,
  input  logic [DELTA_W-1:0] delta_eff,
  input  logic [CUT_W-1:0]   n_eff,
  tscc_out_if.source         out_ch
);

  localparam int NUM_BINS = MAX_CUTS + 1;
  localparam int SUM_W    = COUNT_WIDTH + CUT_W;
  localparam int ENT_W    = 2 * COUNT_WIDTH;
  localparam logic [CUT_W-1:0] LAST_BIN = CUT_W'(MAX_CUTS);
  localparam logic [SUM_W-1:0] CNT_MAX  = SUM_W'({COUNT_WIDTH{1'b1}});
  localparam logic [SUM_W-1:0] OUT_MAX  = SUM_W'(64'hFFFF_FFFF);
  localparam logic [SUM_W-1:0] CLIP     = (CNT_MAX < OUT_MAX) ? CNT_MAX : OUT_MAX;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_BRD    = 8'b0000_0100,
    S_BWR    = 8'b0000_1000,
    S_SUM    = 8'b0001_0000,
    S_SUMX   = 8'b0010_0000,
    S_ROW_RD = 8'b0100_0000,
    S_ROW    = 8'b1000_0000
  } state_t;

  // Saturate a sum to the counter range and to the port width
  function automatic logic [OUT_CNT_W-1:0] clip_cnt(input logic [SUM_W-1:0] v);
    clip_cnt = (v > CLIP) ? OUT_CNT_W'(CLIP) : OUT_CNT_W'(v);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  state_t state_r, state_nxt;

  // Histogram store: {positive, negative} per bin
  logic [ENT_W-1:0]       bin_mem [NUM_BINS];
  logic [ENT_W-1:0]       rd_data_r;
  logic                   rd_ok_r;
  logic [NUM_BINS-1:0]    vld_r;
  logic [CUT_W-1:0]       rd_addr;
  logic                   mem_we;
  logic [ENT_W-1:0]       mem_wdata;
  logic [COUNT_WIDTH-1:0] bin_pos;
  logic [COUNT_WIDTH-1:0] bin_neg;

  logic [COUNT_WIDTH-1:0] tot_pos_r;
  logic [COUNT_WIDTH-1:0] tot_neg_r;
  logic                   pos_r;
  logic [CUT_W-1:0]       idx_r;
  logic [CUT_W-1:0]       sweep_r;
  logic [CUT_W-1:0]       cut_r;
  logic [SUM_W-1:0]       sum_pos_r;
  logic [SUM_W-1:0]       sum_neg_r;
  logic [SUM_W-1:0]       pre_pos_r;
  logic [SUM_W-1:0]       pre_neg_r;
  logic [SUM_W-1:0]       pre_pos_nxt;
  logic [SUM_W-1:0]       pre_neg_nxt;

  logic                   div_start;
  logic                   div_done;
  logic [CUT_W-1:0]       div_idx;
  logic [SEXT_W-1:0]      head_x;
  logic                   row_last;
  logic                   out_load;

  logic                   out_valid_r;
  logic [CUT_IDX_W-1:0]   out_cut_r;
  logic [OUT_CNT_W-1:0]   out_tp_r;
  logic [OUT_CNT_W-1:0]   out_fp_r;
  logic [OUT_CNT_W-1:0]   out_tn_r;
  logic [OUT_CNT_W-1:0]   out_fn_r;
  logic [OUT_CNT_W-1:0]   out_totp_r;
  logic [OUT_CNT_W-1:0]   out_totn_r;
  logic                   out_last_r;

  // x = score - min_value - 1
  assign head_x = head.score + {{(SEXT_W-SCORE_W){~min_value[SCORE_W-1]}}, ~min_value};

  tscc_div #(.CUT_W(CUT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .x     (head_x),
    .d     (delta_eff),
    .n     (n_eff),
    .done  (div_done),
    .idx   (div_idx)
  );

  // Bin read view; never-written bins read as zero
  assign bin_pos = rd_ok_r ? rd_data_r[ENT_W-1:COUNT_WIDTH] : '0;
  assign bin_neg = rd_ok_r ? rd_data_r[COUNT_WIDTH-1:0]     : '0;

  assign mem_wdata = pos_r ? {sat_inc(bin_pos), bin_neg} : {bin_pos, sat_inc(bin_neg)};
  assign mem_we    = (state_r == S_BWR);

  assign pre_pos_nxt = pre_pos_r + SUM_W'(bin_pos);
  assign pre_neg_nxt = pre_neg_r + SUM_W'(bin_neg);
  assign row_last    = (cut_r == n_eff - CUT_W'(1));
  assign out_load    = (state_r == S_ROW) && (!out_valid_r || out_ch.ready);

  // Read address per state
  always_comb begin
    unique case (state_r)
      S_SUM:           rd_addr = sweep_r;
      S_ROW_RD, S_ROW: rd_addr = cut_r;
      default:         rd_addr = idx_r;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.op)
            OP_PAIR: begin
              if (head.scored) begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            OP_READ:  state_nxt = S_SUM;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV:    if (div_done) state_nxt = S_BRD;
      S_BRD:    state_nxt = S_BWR;
      S_BWR:    state_nxt = S_IDLE;
      S_SUM:    if (sweep_r == LAST_BIN) state_nxt = S_SUMX;
      S_SUMX:   state_nxt = S_ROW_RD;
      S_ROW_RD: state_nxt = S_ROW;
      S_ROW:    if (out_load) state_nxt = row_last ? S_IDLE : S_ROW_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Histogram memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[idx_r] <= mem_wdata;
    end
    rd_data_r <= bin_mem[rd_addr];
    rd_ok_r   <= vld_r[rd_addr];
  end

  // Control state: sequencer, bin valid bits, totals, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      tot_pos_r   <= '0;
      tot_neg_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && (head.op == OP_CLEAR)) begin
        vld_r     <= '0;
        tot_pos_r <= '0;
        tot_neg_r <= '0;
      end else if (pop && (head.op == OP_PAIR)) begin
        if (head.pos) begin
          tot_pos_r <= sat_inc(tot_pos_r);
        end else begin
          tot_neg_r <= sat_inc(tot_neg_r);
        end
      end
      if (mem_we) begin
        vld_r[idx_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (pop) begin
      pos_r     <= head.pos;
      sweep_r   <= '0;
      sum_pos_r <= '0;
      sum_neg_r <= '0;
    end
    if ((state_r == S_DIV) && div_done) begin
      idx_r <= div_idx;
    end
    // Full sweep: data arrives the cycle after its address
    if (state_r == S_SUM) begin
      if (sweep_r != '0) begin
        sum_pos_r <= sum_pos_r + SUM_W'(bin_pos);
        sum_neg_r <= sum_neg_r + SUM_W'(bin_neg);
      end
      sweep_r <= sweep_r + CUT_W'(1);
    end
    if (state_r == S_SUMX) begin
      sum_pos_r <= sum_pos_r + SUM_W'(bin_pos);
      sum_neg_r <= sum_neg_r + SUM_W'(bin_neg);
      cut_r     <= '0;
      pre_pos_r <= '0;
      pre_neg_r <= '0;
    end
    if (out_load) begin
      pre_pos_r <= pre_pos_nxt;
      pre_neg_r <= pre_neg_nxt;
      cut_r     <= cut_r + CUT_W'(1);
    end
  end

  // Output row register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cut_r  <= CUT_IDX_W'(cut_r);
      out_tp_r   <= clip_cnt(sum_pos_r - pre_pos_nxt);
      out_fp_r   <= clip_cnt(sum_neg_r - pre_neg_nxt);
      out_tn_r   <= clip_cnt(pre_neg_nxt);
      out_fn_r   <= clip_cnt(pre_pos_nxt);
      out_totp_r <= clip_cnt(SUM_W'(tot_pos_r));
      out_totn_r <= clip_cnt(SUM_W'(tot_neg_r));
      out_last_r <= row_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.cut_index = out_cut_r;
  assign out_ch.true_pos  = out_tp_r;
  assign out_ch.false_pos = out_fp_r;
  assign out_ch.true_neg  = out_tn_r;
  assign out_ch.false_neg = out_fn_r;
  assign out_ch.total_pos = out_totp_r;
  assign out_ch.total_neg = out_totn_r;
  assign out_ch.last      = out_last_r;

`ifndef NO_ASSERTIONS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider result arrived outside the wait state");
  a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && row_last |=> state_r == S_IDLE)
    else $error("readout did not end after its final row");
  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |-> sweep_r <= LAST_BIN)
    else $error("bin sweep ran past the last bin");
`endif

endmodule

/* design/threshold_sweep_confusion_counter.sv */
// Pairs enter a two-entry queue. A scored pair then holds the back end while the
// one-bit-per-cycle divider finds its bin and the bin is read and written back; the
// divider finishes at once when score - min_value is not positive. Unscored pairs and clears
// are done when popped. Readout: the bin sweep reads every bin to form the totals, then
// each row reads its bin (S_ROW_RD) and loads the output (S_ROW); rows stall freely.
// Reset (rst_n low, synchronous) restores register defaults and zeroes all bins and totals.
module threshold_sweep_confusion_counter
  import tscc_pkg::*;
#(
  parameter int MAX_CUTS    = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  tscc_in_if.sink     in_ch,
  tscc_out_if.source  out_ch,
  tscc_cfg_if.sink    cfg_ch
);

  localparam int CUT_W = $clog2(MAX_CUTS + 1);

  logic [SCORE_W-1:0] min_value_r;
  logic [DELTA_W-1:0] delta_r;
  logic [NCUT_W-1:0]  num_cuts_r;
  logic               invert_mode_r;
  logic               filter_enable_r;

  logic [DELTA_W-1:0] delta_eff;
  logic [CUT_W-1:0]   n_eff;

  logic               q_push;
  logic               q_ready;
  qent_t              q_data;
  logic               q_pop;
  logic               q_head_valid;
  qent_t              q_head;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r     <= MIN_VALUE_RST;
      delta_r         <= DELTA_RST;
      num_cuts_r      <= NUM_CUTS_RST;
      invert_mode_r   <= 1'b0;
      filter_enable_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MIN_VALUE: min_value_r     <= cfg_ch.data;
        CFG_DELTA:     delta_r         <= cfg_ch.data[DELTA_W-1:0];
        CFG_NUM_CUTS:  num_cuts_r      <= cfg_ch.data[NCUT_W-1:0];
        CFG_INVERT:    invert_mode_r   <= cfg_ch.data[0];
        CFG_FILTER:    filter_enable_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Zero step acts as one
  assign delta_eff = (delta_r == '0) ? DELTA_W'(1) : delta_r;

  // Cut count held to 1..MAX_CUTS
  always_comb begin
    priority if (num_cuts_r == '0) begin
      n_eff = CUT_W'(1);
    end else if (32'(num_cuts_r) > 32'(MAX_CUTS)) begin
      n_eff = CUT_W'(MAX_CUTS);
    end else begin
      n_eff = CUT_W'(num_cuts_r);
    end
  end

  tscc_front u_front (
    .in_ch         (in_ch),
    .invert_mode   (invert_mode_r),
    .filter_enable (filter_enable_r),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  tscc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  tscc_back #(
    .MAX_CUTS    (MAX_CUTS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .CUT_W       (CUT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .min_value  (min_value_r),
    .delta_eff  (delta_eff),
    .n_eff      (n_eff),
    .out_ch     (out_ch)
  );

endmodule
